### rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator: field
// widths, request and status codes, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
package gha_pkg;

    // default sizing
    localparam int SLOTS_DEF    = 1024;
    localparam int GEN_BITS_DEF = 32;

    // fixed port field widths
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;
    localparam int GEN_W    = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEAD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                alive;
        logic [INDEX_W-1:0]  index;
        logic [GEN_W-1:0]    gen;
    } result_t;

endpackage

### rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Request sequencer: captures a request, reads the free stack and generation
// memories, decides the result and writes back generation, stack and counters.
// ----------------------------------------------------------------------------
module gha_ctrl import gha_pkg::*; #(
    parameter int   SLOTS    = SLOTS_DEF,
    parameter int   GEN_BITS = GEN_BITS_DEF,
    localparam int  IDX_W    = $clog2(SLOTS),
    localparam int  CNT_W    = $clog2(SLOTS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    // request side
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [INDEX_W-1:0]  handle_index,
    input  logic [GEN_W-1:0]    handle_gen,
    // result side
    input  logic                out_ready,
    output logic                res_load,
    output result_t             res,
    // generation memory
    output logic                gen_rd_en,
    output logic [IDX_W-1:0]    gen_rd_addr,
    input  logic [GEN_BITS-1:0] gen_rd_data,
    output logic                gen_wr_en,
    output logic [IDX_W-1:0]    gen_wr_addr,
    output logic [GEN_BITS-1:0] gen_wr_data,
    // free stack memory
    output logic                stk_rd_en,
    output logic [IDX_W-1:0]    stk_rd_addr,
    input  logic [IDX_W-1:0]    stk_rd_data,
    output logic                stk_wr_en,
    output logic [IDX_W-1:0]    stk_wr_addr,
    output logic [IDX_W-1:0]    stk_wr_data
);

    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    state_t             state_reg, state_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [CMP_W-1:0]   idx_reg, idx_next;
    logic [GEN_W-1:0]   hgen_reg, hgen_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]   high_water_reg, high_water_next;

    logic               accept;
    logic               commit;
    logic               depth_nz;
    logic [CMP_W-1:0]   idx_ext;
    logic               live;
    logic               do_pop;
    logic               do_push;
    logic               do_fresh;
    logic               do_bump;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign depth_nz = (free_depth_reg != '0);
    assign idx_ext  = CMP_W'(handle_index);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if ((req_type == REQ_CREATE) && depth_nz)
                        state_next = S_POP;
                    else
                        state_next = S_EXEC;
                end
            end
            S_POP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs and memory read addressing
    always_comb
    begin
        in_stall    = (state_reg != S_IDLE);
        commit      = (state_reg == S_EXEC) && out_ready;
        stk_rd_en   = accept;
        stk_rd_addr = IDX_W'(free_depth_reg - 1'b1);
        gen_rd_en   = accept || (state_reg == S_POP);
        gen_rd_addr = (state_reg == S_POP) ? stk_rd_data : idx_ext[IDX_W-1:0];
    end

    // request capture
    always_comb
    begin
        req_next  = req_reg;
        idx_next  = idx_reg;
        hgen_next = hgen_reg;
        slot_next = slot_reg;
        if (accept)
        begin
            req_next  = req_type;
            idx_next  = idx_ext;
            hgen_next = handle_gen;
        end
        if (state_reg == S_POP)
        begin
            slot_next = stk_rd_data;
        end
    end

    // liveness: below the high-water mark and generation matches in full
    assign live = (idx_reg < CMP_W'(high_water_reg)) &&
                  (GEN_W'(gen_rd_data) == hgen_reg);

    // result decision
    always_comb
    begin
        res      = '0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        do_fresh = 1'b0;
        do_bump  = 1'b0;
        unique case (req_reg)
            REQ_CREATE:
            begin
                if (depth_nz)
                begin
                    do_pop    = 1'b1;
                    res.index = INDEX_W'(slot_reg);
                    res.gen   = GEN_W'(gen_rd_data);
                end
                else if (high_water_reg != SLOTS_C)
                begin
                    do_fresh  = 1'b1;
                    res.index = INDEX_W'(high_water_reg);
                    res.gen   = GEN_W'(1);
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            REQ_DESTROY:
            begin
                if (live)
                begin
                    res.alive = 1'b1;
                    do_bump   = 1'b1;
                    do_push   = (free_depth_reg != SLOTS_C);
                end
                else
                begin
                    res.status = ST_DEAD;
                end
            end
            REQ_CHECK:
            begin
                res.alive = live;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // write-back of memories, gated by commit
    always_comb
    begin
        res_load    = commit;
        gen_wr_en   = commit && (do_fresh || do_bump);
        gen_wr_addr = do_fresh ? IDX_W'(high_water_reg) : idx_reg[IDX_W-1:0];
        gen_wr_data = do_fresh ? GEN_BITS'(1) : GEN_BITS'(gen_rd_data + 1'b1);
        stk_wr_en   = commit && do_push;
        stk_wr_addr = IDX_W'(free_depth_reg);
        stk_wr_data = idx_reg[IDX_W-1:0];
    end

    // stack depth and high-water counters
    always_comb
    begin
        free_depth_next = free_depth_reg;
        high_water_next = high_water_reg;
        if (commit && do_pop)
            free_depth_next = free_depth_reg - 1'b1;
        else if (commit && do_push)
            free_depth_next = free_depth_reg + 1'b1;
        if (commit && do_fresh)
            high_water_next = high_water_reg + 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_depth_reg <= '0;
            high_water_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_depth_reg <= free_depth_next;
            high_water_reg <= high_water_next;
        end
    end

    // request payload registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        idx_reg  <= idx_next;
        hgen_reg <= hgen_next;
        slot_reg <= slot_next;
    end

    // checks
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_depth_reg <= SLOTS_C)
        else $error("free stack depth beyond capacity");

    a_water_bound: assert property (@(posedge clk) disable iff (!rst_n)
        high_water_reg <= SLOTS_C)
        else $error("high-water mark beyond capacity");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        stk_wr_en |=> (free_depth_reg == $past(free_depth_reg) + 1'b1))
        else $error("stack push without depth increment");

    a_gen_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        gen_wr_en |-> (CMP_W'(gen_wr_addr) <= CMP_W'(high_water_reg)))
        else $error("generation write above high-water mark");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> depth_nz)
        else $error("pop from empty free stack");

endmodule

### rtl/gha_out.sv
// ----------------------------------------------------------------------------
// gha_out
// Result output register: holds one result until the downstream side takes
// it, and frees up as it is taken so the sequencer can load the next one.
// ----------------------------------------------------------------------------
module gha_out import gha_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  result_t             res,
    output logic                out_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                alive,
    output logic [INDEX_W-1:0]  out_index,
    output logic [GEN_W-1:0]    out_gen
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    // free when empty or when the held result transfers this cycle
    assign out_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = res;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign status    = res_reg.status;
    assign alive     = res_reg.alive;
    assign out_index = res_reg.index;
    assign out_gen   = res_reg.gen;

endmodule

### rtl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out slot index plus generation handles, recycles freed slots through
// a LIFO free stack and answers destroy and liveness requests.
// ----------------------------------------------------------------------------
// One request is taken at a time. Every request but a create that pops the
// free stack goes from IDLE to EXEC, loads its result into the output
// register in EXEC and returns to IDLE to take the next request; a create
// that pops the free stack passes through POP first, since the stack read
// and the generation read that depends on it are each one synchronous memory
// read. The request side stalls while a request is in progress, and a
// finished request also waits while the output register still holds an
// earlier result that is stalled; otherwise a new request is taken while a
// result still waits.
// Generations and the free stack live in two memories of SLOTS entries. No
// clearing pass runs after reset: every slot below the high-water mark has its
// generation written when first handed out, and slots at or above it fail the
// liveness check. Only the low ten bits of a slot index appear on the ports.
// ----------------------------------------------------------------------------
module generational_handle_allocator import gha_pkg::*; #(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [INDEX_W-1:0]  handle_index,
    input  logic [GEN_W-1:0]    handle_gen,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                alive,
    output logic [INDEX_W-1:0]  out_index,
    output logic [GEN_W-1:0]    out_gen
);

    localparam int IDX_W = $clog2(SLOTS);

    logic                out_ready;
    logic                res_load;
    result_t             res;

    logic                gen_rd_en;
    logic [IDX_W-1:0]    gen_rd_addr;
    logic [GEN_BITS-1:0] gen_rd_data;
    logic                gen_wr_en;
    logic [IDX_W-1:0]    gen_wr_addr;
    logic [GEN_BITS-1:0] gen_wr_data;

    logic                stk_rd_en;
    logic [IDX_W-1:0]    stk_rd_addr;
    logic [IDX_W-1:0]    stk_rd_data;
    logic                stk_wr_en;
    logic [IDX_W-1:0]    stk_wr_addr;
    logic [IDX_W-1:0]    stk_wr_data;

    // request sequencer
    gha_ctrl #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .handle_index (handle_index),
        .handle_gen   (handle_gen),
        .out_ready    (out_ready),
        .res_load     (res_load),
        .res          (res),
        .gen_rd_en    (gen_rd_en),
        .gen_rd_addr  (gen_rd_addr),
        .gen_rd_data  (gen_rd_data),
        .gen_wr_en    (gen_wr_en),
        .gen_wr_addr  (gen_wr_addr),
        .gen_wr_data  (gen_wr_data),
        .stk_rd_en    (stk_rd_en),
        .stk_rd_addr  (stk_rd_addr),
        .stk_rd_data  (stk_rd_data),
        .stk_wr_en    (stk_wr_en),
        .stk_wr_addr  (stk_wr_addr),
        .stk_wr_data  (stk_wr_data)
    );

    // generation table
    gha_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .clk     (clk),
        .wr_en   (gen_wr_en),
        .wr_addr (gen_wr_addr),
        .wr_data (gen_wr_data),
        .rd_en   (gen_rd_en),
        .rd_addr (gen_rd_addr),
        .rd_data (gen_rd_data)
    );

    // free index stack
    gha_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_stk_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // result register
    gha_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .alive     (alive),
        .out_index (out_index),
        .out_gen   (out_gen)
    );

endmodule

### sim/tb_generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator
// Self-checking bench for the generational handle allocator. A shadow copy of
// the generation table, free stack and high-water mark predicts the result of
// every accepted request; results are matched in order, field by field.
// Stimulus runs a short directed sequence, then a mixed workload, a fill to
// the allocator-full condition and a burst of destroys on one slot, under
// varying request gaps and result back-pressure.
// ----------------------------------------------------------------------------

// shadow of the allocator state plus the queue of results still owed
class allocator_shadow;
    logic [gha_pkg::GEN_W-1:0]   gen_table [gha_pkg::SLOTS_DEF];
    logic [gha_pkg::INDEX_W-1:0] free_stack [gha_pkg::SLOTS_DEF];
    int                          free_depth;
    int                          high_water;
    gha_pkg::result_t            awaited_results [$];
    int                          mismatches;
    int                          requests;
    int                          checked;
    int                          full_hits;
    int                          overflow_hits;

    function new();
        foreach (gen_table[i]) gen_table[i] = 1;
        foreach (free_stack[i]) free_stack[i] = '0;
        free_depth    = 0;
        high_water    = 0;
        mismatches    = 0;
        requests      = 0;
        checked       = 0;
        full_hits     = 0;
        overflow_hits = 0;
    endfunction

    function bit is_live(input logic [gha_pkg::INDEX_W-1:0] idx,
                         input logic [gha_pkg::GEN_W-1:0] gen);
        if (int'(idx) >= high_water)
            return 1'b0;
        return gen_table[idx] == gen;
    endfunction

    // apply one accepted request and queue the result it owes
    function void note_request(input logic [gha_pkg::REQ_W-1:0] req,
                               input logic [gha_pkg::INDEX_W-1:0] idx,
                               input logic [gha_pkg::GEN_W-1:0] gen);
        gha_pkg::result_t r;
        int               slot;
        r = '0;
        requests++;
        case (req)
            gha_pkg::REQ_CREATE:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    slot = free_stack[free_depth];
                    r.index = slot[gha_pkg::INDEX_W-1:0];
                    r.gen   = gen_table[slot];
                end
                else if (high_water < gha_pkg::SLOTS_DEF)
                begin
                    slot = high_water;
                    high_water++;
                    r.index = slot[gha_pkg::INDEX_W-1:0];
                    r.gen   = gen_table[slot];
                end
                else
                begin
                    r.status = gha_pkg::ST_FULL;
                    full_hits++;
                end
            end
            gha_pkg::REQ_DESTROY:
            begin
                if (is_live(idx, gen))
                begin
                    r.alive = 1'b1;
                    gen_table[idx] = gen_table[idx] + 1;
                    if (free_depth < gha_pkg::SLOTS_DEF)
                    begin
                        free_stack[free_depth] = idx;
                        free_depth++;
                    end
                    else
                        overflow_hits++;
                end
                else
                    r.status = gha_pkg::ST_DEAD;
            end
            gha_pkg::REQ_CHECK:
                r.alive = is_live(idx, gen);
            default:
                r = '0;
        endcase
        awaited_results.push_back(r);
    endfunction

    // match one accepted result against the oldest owed result
    function void compare_result(input logic [gha_pkg::STATUS_W-1:0] status,
                                 input logic alive,
                                 input logic [gha_pkg::INDEX_W-1:0] index,
                                 input logic [gha_pkg::GEN_W-1:0] gen);
        gha_pkg::result_t e;
        if (awaited_results.size() == 0)
        begin
            $error("result transfer with no request outstanding");
            mismatches++;
            return;
        end
        e = awaited_results.pop_front();
        checked++;
        if (status !== e.status)
        begin
            $error("status: expected %0d, actual %0d", e.status, status);
            mismatches++;
        end
        if (alive !== e.alive)
        begin
            $error("alive: expected %0d, actual %0d", e.alive, alive);
            mismatches++;
        end
        if (index !== e.index)
        begin
            $error("out_index: expected %0d, actual %0d", e.index, index);
            mismatches++;
        end
        if (gen !== e.gen)
        begin
            $error("out_gen: expected 0x%08h, actual 0x%08h", e.gen, gen);
            mismatches++;
        end
    endfunction
endclass

module tb_generational_handle_allocator;
    import gha_pkg::*;

    localparam int NUM_SLOTS      = SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type     = REQ_CREATE;
    logic [INDEX_W-1:0]  handle_index = '0;
    logic [GEN_W-1:0]    handle_gen   = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                alive;
    logic [INDEX_W-1:0]  out_index;
    logic [GEN_W-1:0]    out_gen;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    allocator_shadow ledger;

    generational_handle_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .handle_index (handle_index),
        .handle_gen   (handle_gen),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .alive        (alive),
        .out_index    (out_index),
        .out_gen      (out_gen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.compare_result(status, alive, out_index, out_gen);
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("[generational_handle_allocator] ERROR");
            $finish;
        end
    end

    // present one request, hold it until the transfer, then record it
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [INDEX_W-1:0] idx,
                                input logic [GEN_W-1:0] gen);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        handle_index <= idx;
        handle_gen   <= gen;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_request(req, idx, gen);
    endtask

    // handle for destroy or check: mostly live, some stale, out of range or junk
    task automatic pick_handle(output logic [INDEX_W-1:0] idx,
                               output logic [GEN_W-1:0] gen);
        int roll;
        int hw;
        roll = $urandom_range(0, 99);
        hw   = ledger.high_water;
        if (hw > 0 && roll < 60)
        begin
            idx = INDEX_W'($urandom_range(0, hw - 1));
            gen = ledger.gen_table[idx];
        end
        else if (hw > 0 && roll < 80)
        begin
            idx = INDEX_W'($urandom_range(0, hw - 1));
            gen = $urandom_range(0, 1) ? ledger.gen_table[idx] - 1
                                        : ledger.gen_table[idx] + 1;
        end
        else if (hw < NUM_SLOTS && roll < 90)
        begin
            idx = INDEX_W'($urandom_range(hw, NUM_SLOTS - 1));
            gen = $urandom_range(0, 1) ? 32'd1 : GEN_W'($urandom);
        end
        else
        begin
            idx = INDEX_W'($urandom);
            gen = GEN_W'($urandom);
        end
    endtask

    function automatic logic [REQ_W-1:0] REQ_TYPE_RAND();
        return REQ_W'($urandom_range(0, 3));
    endfunction

    // one random request; weights in percent, remainder is noise
    task automatic send_mixed(input int create_w, input int destroy_w, input int check_w);
        int                 roll;
        logic [INDEX_W-1:0] idx;
        logic [GEN_W-1:0]   gen;
        roll = $urandom_range(0, 99);
        if (roll < create_w)
            send_request(REQ_CREATE, INDEX_W'($urandom), GEN_W'($urandom));
        else if (roll < create_w + destroy_w)
        begin
            pick_handle(idx, gen);
            send_request(REQ_DESTROY, idx, gen);
        end
        else if (roll < create_w + destroy_w + check_w)
        begin
            pick_handle(idx, gen);
            send_request(REQ_CHECK, idx, gen);
        end
        else
            send_request(REQ_TYPE_RAND(), INDEX_W'($urandom), GEN_W'($urandom));
    endtask

    initial
    begin
        int               slot;
        int               guard;
        logic [GEN_W-1:0] gen;
        ledger = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender mostly busy, receiver stalling heavily
        send_idle_pct = 9;
        recv_idle_pct = 58;

        // directed: first handles, stale and freed handles, duplicates, odd codes
        send_request(REQ_CREATE,  10'd0,    32'd0);
        send_request(REQ_CREATE,  10'd1023, 32'hFFFF_FFFF);
        send_request(REQ_CHECK,   10'd0,    32'd1);
        send_request(REQ_CHECK,   10'd1,    32'd2);
        send_request(REQ_CHECK,   10'd5,    32'd1);
        send_request(REQ_DESTROY, 10'd0,    32'd1);
        send_request(REQ_DESTROY, 10'd0,    32'd1);
        send_request(REQ_CHECK,   10'd0,    32'd2);
        send_request(REQ_DESTROY, 10'd0,    32'd2);
        send_request(REQ_CREATE,  10'd0,    32'd0);
        send_request(REQ_CREATE,  10'd0,    32'd0);
        send_request(REQ_CREATE,  10'd0,    32'd0);
        send_request(REQ_UNUSED,  10'd1023, 32'hFFFF_FFFF);
        send_request(REQ_CHECK,   10'd1023, 32'hFFFF_FFFF);
        send_request(REQ_DESTROY, 10'd1023, 32'd0);
        send_request(REQ_CHECK,   10'd1,    32'd0);
        send_request(REQ_DESTROY, 10'd1,    32'd1);
        send_request(REQ_CHECK,   10'd0,    32'hFFFF_FFFF);
        send_request(REQ_DESTROY, 10'd2,    32'h8000_0001);
        send_request(REQ_UNUSED,  10'd0,    32'd0);

        // mixed workload
        repeat (300)
            send_mixed(35, 30, 25);

        // fill every slot until creates report full, roles swapped
        send_idle_pct = 58;
        recv_idle_pct = 9;
        guard = 0;
        while (ledger.full_hits < 6 && guard < 4000)
        begin
            send_mixed(75, 10, 10);
            guard++;
        end

        // hammer one slot with destroys at its current generation, which stays live after each free
        send_idle_pct = 0;
        recv_idle_pct = 0;
        slot = $urandom_range(0, ledger.high_water - 1);
        repeat (40)
        begin
            if ($urandom_range(0, 99) < 92)
            begin
                gen = ledger.gen_table[slot];
                send_request(REQ_DESTROY, slot[INDEX_W-1:0], gen);
            end
            else
                send_mixed(40, 0, 50);
        end
        repeat (60)
            send_mixed(40, 25, 25);
        in_valid <= 1'b0;

        // drain owed results, then allow for stray transfers
        while (ledger.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests, %0d results checked; %0d creates hit a full allocator,",
                 ledger.requests, ledger.checked, ledger.full_hits);
        $display("%0d frees dropped on a full stack, high-water mark %0d",
                 ledger.overflow_hits, ledger.high_water);
        if (ledger.mismatches == 0 && ledger.awaited_results.size() == 0)
            $display("[generational_handle_allocator] OK");
        else
            $display("[generational_handle_allocator] ERROR");
        $finish;
    end

endmodule
